FILE: rtl/core/assert_macros.svh
// assertion macros for the keyboard report differ
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/hkrd_pkg.sv
// shared constants, types and register codes for the keyboard report differ
// no dependencies
package hkrd_pkg;

	localparam int MOD_BITS   = 8;
	localparam int KEY_SLOTS  = 6;
	localparam int KEY_W      = 8;
	localparam int CODE_W     = 16;
	localparam int EV_BITS    = MOD_BITS + 2 * KEY_SLOTS;
	localparam int EV_IDX_W   = $clog2(EV_BITS);
	localparam int SLOT_IDX_W = $clog2(KEY_SLOTS);
	localparam int MOD_IDX_W  = $clog2(MOD_BITS);
	localparam int REG_IDX_W  = 1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MOD_BASE = 1'b0,
		REG_KEY_BASE = 1'b1
	} reg_idx_t;

	typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_set_t;

	// one report worth of pending events
	typedef struct packed {
		logic [EV_BITS-1:0]  mask;
		logic [MOD_BITS-1:0] mods;
		key_set_t            now;
		key_set_t            prev;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/core/hkrd_front.sv
// front end: takes report words, diffs them against the held report
// and builds the event mask; depends on hkrd_pkg
module hkrd_front
	import hkrd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                ack,
	input  logic [MOD_BITS-1:0] modifiers,
	input  key_set_t            keys,
	input  q_stat_t             q_stat,
	output logic                q_push,
	output job_t                q_data
);

	logic [MOD_BITS-1:0] prev_mods_q;
	key_set_t            prev_keys_q;
	logic                take;
	logic [KEY_SLOTS-1:0] held_prev, held_now, differ, press, rel;

	assign in_stall = q_stat.full;
	assign take     = in_valid && !q_stat.full && ack;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			held_prev[i] = 1'b0;
			held_now[i]  = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_keys_q[j] == keys[i])
					held_prev[i] = 1'b1;
				if (keys[j] == prev_keys_q[i])
					held_now[i] = 1'b1;
			end
			differ[i] = keys[i] != prev_keys_q[i];
			press[i]  = differ[i] && (keys[i] != '0) && !held_prev[i];
			rel[i]    = differ[i] && (prev_keys_q[i] != '0) && !held_now[i];
		end
	end

	always_comb begin
		q_data.mods = modifiers;
		q_data.now  = keys;
		q_data.prev = prev_keys_q;
		q_data.mask[MOD_BITS-1:0] = modifiers ^ prev_mods_q;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			q_data.mask[MOD_BITS + 2*i]     = press[i];
			q_data.mask[MOD_BITS + 2*i + 1] = rel[i];
		end
	end

	assign q_push = take && (q_data.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (take) begin
			prev_mods_q <= modifiers;
			prev_keys_q <= keys;
		end
	end

endmodule

FILE: rtl/core/hkrd_queue.sv
// two-entry queue of pending report jobs between front and back
// depends on hkrd_pkg
module hkrd_queue
	import hkrd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_data,
	input  logic    pop,
	output job_t    pop_data,
	output q_stat_t stat
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign stat.full  = count_q == 2'd2;
	assign stat.empty = count_q == 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/hkrd_back.sv
// back end: walks one job's event mask to the output register, one event word
// per cycle unless stalled; holds the code base registers; depends on hkrd_pkg
module hkrd_back
	import hkrd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CODE_W-1:0]    wr_data,
	input  q_stat_t              q_stat,
	input  job_t                 q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CODE_W-1:0]    event_code,
	output logic                 pressed,
	output logic                 last_event
);

	logic [CODE_W-1:0]   mod_base_q, key_base_q;
	job_t                cur_q;
	logic [EV_BITS-1:0]  rem_q, rem_clr;
	logic                cur_valid_q, advance, last, load;
	logic [EV_IDX_W-1:0] idx, idx_off;
	logic [SLOT_IDX_W-1:0] slot;
	logic [CODE_W-1:0]   code;
	logic                press_bit;
	logic                out_valid_q, pressed_q, last_q;
	logic [CODE_W-1:0]   event_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_base_q <= '0;
			key_base_q <= CODE_W'(256);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MOD_BASE: mod_base_q <= wr_data;
				REG_KEY_BASE: key_base_q <= wr_data;
				default:      mod_base_q <= mod_base_q;
			endcase
		end
	end

	// lowest pending event
	always_comb begin
		idx = '0;
		for (int i = EV_BITS - 1; i >= 0; i--) begin
			if (rem_q[i])
				idx = EV_IDX_W'(i);
		end
	end

	assign rem_clr = rem_q & (rem_q - EV_BITS'(1));
	assign last    = rem_clr == '0;
	assign idx_off = idx - EV_IDX_W'(MOD_BITS);
	assign slot    = idx_off[SLOT_IDX_W:1];

	always_comb begin
		if (idx < EV_IDX_W'(MOD_BITS)) begin
			code      = mod_base_q + CODE_W'(idx);
			press_bit = cur_q.mods[idx[MOD_IDX_W-1:0]];
		end else if (!idx_off[0]) begin
			code      = key_base_q + CODE_W'(cur_q.now[slot]);
			press_bit = 1'b1;
		end else begin
			code      = key_base_q + CODE_W'(cur_q.prev[slot]);
			press_bit = 1'b0;
		end
	end

	assign advance = cur_valid_q && (!out_valid_q || !out_stall);
	assign load    = !q_stat.empty && (!cur_valid_q || (advance && last));
	assign q_pop   = load;

	always_ff @(posedge clk) begin
		if (load)
			cur_q <= q_data;
		if (advance) begin
			event_code_q <= code;
			pressed_q    <= press_bit;
			last_q       <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				rem_q       <= q_data.mask;
			end else if (advance) begin
				cur_valid_q <= !last;
				rem_q       <= rem_clr;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_code_q;
	assign pressed    = pressed_q;
	assign last_event = last_q;

endmodule

FILE: rtl/core/hid_keyboard_report_differ.sv
// top level of the keyboard report differ: front, job queue and back
// depends on hkrd_pkg, hkrd_front, hkrd_queue, hkrd_back, assert_macros.svh
//
// input channel: one word per boot keyboard report (ack, modifier byte,
// six key slots), taken when in_valid is high and in_stall low; a word
// with ack low is taken and dropped without touching the held report
// output channel: one key event word per handshake (event_code, pressed,
// last_event), last_event marks the final event of a report
// a report that changes nothing gives no event words
// the first event word of a report passes through the job queue, the
// current job register and the output register of the back end
// throughput: one event word per cycle out of the back end while the
// output is not stalled; a report has 1 to 20 events; the front takes a
// report per cycle while the two-entry job queue has room
// in_stall rises only when the job queue is full; an output stall holds
// the event word in the output register and backs up into the queue
// reset clears the held report to nothing pressed, the modifier code base
// to 0 and the key code base to 256; base registers are written on wr_en
`include "assert_macros.svh"

module hid_keyboard_report_differ
	import hkrd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CODE_W-1:0]    wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 ack,
	input  logic [MOD_BITS-1:0]  modifiers,
	input  logic [KEY_W-1:0]     key_slot0,
	input  logic [KEY_W-1:0]     key_slot1,
	input  logic [KEY_W-1:0]     key_slot2,
	input  logic [KEY_W-1:0]     key_slot3,
	input  logic [KEY_W-1:0]     key_slot4,
	input  logic [KEY_W-1:0]     key_slot5,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CODE_W-1:0]    event_code,
	output logic                 pressed,
	output logic                 last_event
);

	key_set_t keys;
	q_stat_t  q_stat;
	logic     q_push, q_pop;
	job_t     push_data, pop_data;

	assign keys = {key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0};

	hkrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ack       (ack),
		.modifiers (modifiers),
		.keys      (keys),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	hkrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	hkrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.q_stat     (q_stat),
		.q_data     (pop_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.pressed    (pressed),
		.last_event (last_event)
	);

	`ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "job pushed into full queue")
	`ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from empty queue")
	`ASSERT_NEXT(a_events_back_to_back, out_valid && !out_stall && !last_event, out_valid, "gap inside a report's events")

endmodule
